FILE: rtl/core/plle_pkg.sv
// Shared types, codes and field layout of the positional linked-list engine.
package plle_pkg;

  localparam int DEFAULT_POOL_DEPTH = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_OUT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Decoded form of an accepted word against the current list.
  typedef enum logic [3:0] {
    K_NOP,
    K_FULL,
    K_INS_EMPTY,
    K_INS_FRONT,
    K_INS_BACK,
    K_INS_AFTER,
    K_DEL_EMPTY,
    K_DEL_HEAD,
    K_DEL_MID,
    K_READ_EMPTY,
    K_READ
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD,
    OP_ADV,
    OP_INS_EMPTY,
    OP_INS_FRONT,
    OP_INS_BACK1,
    OP_INS_BACK2,
    OP_INS_AFT1,
    OP_INS_AFT2,
    OP_DEL_HEAD,
    OP_DEL_MID
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
  } dp_ctrl_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_one;
    logic  out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/plle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/plle_datapath.sv
// Datapath: list pointers, free map, node memories and the output register.
module plle_datapath #(
  parameter int POOL_DEPTH = plle_pkg::DEFAULT_POOL_DEPTH,
  parameter int DATA_WIDTH = plle_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plle_pkg::dp_ctrl_t                 ctrl,
  output plle_pkg::dp_stat_t                 stat,
  input  logic [plle_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [plle_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [plle_pkg::STATUS_W-1:0]      out_tuser,
  output logic                               out_tlast
);
  import plle_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int CW = LW;
  localparam logic [LW-1:0] NIL      = LW'(POOL_DEPTH);
  localparam logic [CW-1:0] FULL_LEN = CW'(POOL_DEPTH);

  logic [CMD_W-1:0]   in_cmd;
  logic [POS_W-1:0]   in_pos;
  logic [VALUE_W-1:0] in_value;

  kind_t                 kind_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         cnt_r;
  logic [LW-1:0]         cur_r;
  logic [LW-1:0]         prev_r;
  logic [IW-1:0]         new_r;
  logic [LW-1:0]         head_r;
  logic [LW-1:0]         tail_r;
  logic [CW-1:0]         len_r;
  logic [POOL_DEPTH-1:0] used_r;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_last_r;

  kind_t                 kind_nxt;
  logic [CW-1:0]         cnt_nxt;
  logic [COUNT_W-1:0]    len7;
  logic [COUNT_W-1:0]    clamp_pos;
  logic [COUNT_W-1:0]    del_pos;
  logic [IW-1:0]         alloc_idx;

  logic                  data_we;
  logic                  link_we;
  logic [IW-1:0]         link_waddr;
  logic [LW-1:0]         link_wdata;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [LW-1:0]         rd_link;
  logic                  out_free;
  logic [STATUS_W-1:0]   emit_status;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_pos   = in_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value = in_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];

  // Lowest free node wins.
  always_comb begin
    alloc_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        alloc_idx = IW'(i);
      end
    end
  end

  // Classify the incoming word against the current list.
  always_comb begin
    len7      = COUNT_W'(len_r);
    clamp_pos = (in_pos > len7) ? len7 : in_pos;
    del_pos   = (in_pos == '0) ? COUNT_W'(1) : clamp_pos;
    kind_nxt  = K_NOP;
    cnt_nxt   = '0;
    case (in_cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AFTER: begin
        if (len_r == FULL_LEN) begin
          kind_nxt = K_FULL;
        end else if (len_r == '0) begin
          kind_nxt = K_INS_EMPTY;
        end else if (in_cmd == CMD_INS_FRONT || (in_cmd == CMD_INS_AFTER && in_pos == '0)) begin
          kind_nxt = K_INS_FRONT;
        end else if (in_cmd == CMD_INS_BACK) begin
          kind_nxt = K_INS_BACK;
        end else begin
          kind_nxt = K_INS_AFTER;
          cnt_nxt  = CW'(clamp_pos - COUNT_W'(1));
        end
      end
      CMD_DELETE: begin
        if (len_r == '0) begin
          kind_nxt = K_DEL_EMPTY;
        end else if (del_pos == COUNT_W'(1)) begin
          kind_nxt = K_DEL_HEAD;
        end else begin
          kind_nxt = K_DEL_MID;
          cnt_nxt  = CW'(del_pos - COUNT_W'(2));
        end
      end
      CMD_READ_OUT: begin
        if (len_r == '0) begin
          kind_nxt = K_READ_EMPTY;
        end else begin
          kind_nxt = K_READ;
          cnt_nxt  = len_r;
        end
      end
      default: begin
        kind_nxt = K_NOP;
      end
    endcase
  end

  // Memory write ports.
  always_comb begin
    data_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = new_r;
    link_wdata = NIL;
    case (ctrl.op)
      OP_INS_EMPTY: begin
        data_we = 1'b1;
        link_we = 1'b1;
      end
      OP_INS_FRONT: begin
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_wdata = head_r;
      end
      OP_INS_BACK1: begin
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = tail_r[IW-1:0];
        link_wdata = LW'(new_r);
      end
      OP_INS_BACK2: begin
        link_we = 1'b1;
      end
      OP_INS_AFT1: begin
        data_we    = 1'b1;
        link_we    = 1'b1;
        link_wdata = rd_link;
      end
      OP_INS_AFT2: begin
        link_we    = 1'b1;
        link_waddr = cur_r[IW-1:0];
        link_wdata = LW'(new_r);
      end
      OP_DEL_MID: begin
        link_we    = 1'b1;
        link_waddr = prev_r[IW-1:0];
        link_wdata = rd_link;
      end
      default: begin
        data_we = 1'b0;
      end
    endcase
  end

  plle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_data_ram (
    .clk     (clk),
    .we      (data_we),
    .waddr   (new_r),
    .wdata   (val_r),
    .re      (ctrl.op == OP_RD),
    .raddr   (cur_r[IW-1:0]),
    .rdata_r (rd_data)
  );

  plle_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .waddr   (link_waddr),
    .wdata   (link_wdata),
    .re      (ctrl.op == OP_RD),
    .raddr   (cur_r[IW-1:0]),
    .rdata_r (rd_link)
  );

  // List state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL;
      tail_r <= NIL;
      len_r  <= '0;
      used_r <= '0;
      kind_r <= K_NOP;
    end else begin
      case (ctrl.op)
        OP_LOAD: begin
          kind_r <= kind_nxt;
        end
        OP_INS_EMPTY: begin
          head_r        <= LW'(new_r);
          tail_r        <= LW'(new_r);
          used_r[new_r] <= 1'b1;
          len_r         <= len_r + CW'(1);
        end
        OP_INS_FRONT: begin
          head_r        <= LW'(new_r);
          used_r[new_r] <= 1'b1;
          len_r         <= len_r + CW'(1);
        end
        OP_INS_BACK1: begin
          tail_r        <= LW'(new_r);
          used_r[new_r] <= 1'b1;
          len_r         <= len_r + CW'(1);
        end
        OP_INS_AFT1: begin
          if (cur_r == tail_r) begin
            tail_r <= LW'(new_r);
          end
          used_r[new_r] <= 1'b1;
          len_r         <= len_r + CW'(1);
        end
        OP_DEL_HEAD: begin
          if (len_r == CW'(1)) begin
            head_r <= NIL;
            tail_r <= NIL;
          end else begin
            head_r <= rd_link;
          end
          used_r[cur_r[IW-1:0]] <= 1'b0;
          len_r                 <= len_r - CW'(1);
        end
        OP_DEL_MID: begin
          if (cur_r == tail_r) begin
            tail_r <= prev_r;
          end
          used_r[cur_r[IW-1:0]] <= 1'b0;
          len_r                 <= len_r - CW'(1);
        end
        default: begin
          len_r <= len_r;
        end
      endcase
    end
  end

  // Walk registers and captured word.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        val_r <= DATA_WIDTH'(in_value);
        cnt_r <= cnt_nxt;
        cur_r <= head_r;
        new_r <= alloc_idx;
      end
      OP_ADV: begin
        prev_r <= cur_r;
        cur_r  <= rd_link;
        cnt_r  <= cnt_r - CW'(1);
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (kind_r)
      K_FULL:                   emit_status = ST_OVERFLOW;
      K_DEL_EMPTY, K_READ_EMPTY: emit_status = ST_UNDERFLOW;
      default:                  emit_status = ST_OK;
    endcase
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_value_r  <= (kind_r == K_READ) ? VALUE_W'(rd_data) : '0;
      out_status_r <= emit_status;
      out_count_r  <= COUNT_W'(len_r);
      out_last_r   <= (kind_r != K_READ) || (cnt_r == CW'(1));
    end
  end

  assign stat.kind     = kind_r;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_one  = (cnt_r == CW'(1));
  assign stat.out_free = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (len_r == '0))
    else $error("head pointer disagrees with list length");

  a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r == NIL) == (len_r == '0))
    else $error("tail pointer disagrees with list length");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(len_r))
    else $error("free map disagrees with list length");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> out_free)
    else $error("word emitted over an untaken result");

endmodule

FILE: rtl/core/plle_ctrl.sv
// Controller: sequences list walks and updates for one command word at a time.
module plle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  plle_pkg::dp_stat_t stat,
  output plle_pkg::dp_ctrl_t ctrl
);
  import plle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_STEP,
    S_AFT1,
    S_AFT2,
    S_BACK2,
    S_DEL_HEAD,
    S_DEL_ADV,
    S_DEL_RD,
    S_DEL_MID,
    S_EMIT,
    S_RO_RD,
    S_RO_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = OP_NONE;
    ctrl.emit = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.op   = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.kind)
          K_INS_EMPTY: begin
            ctrl.op   = OP_INS_EMPTY;
            state_nxt = S_EMIT;
          end
          K_INS_FRONT: begin
            ctrl.op   = OP_INS_FRONT;
            state_nxt = S_EMIT;
          end
          K_INS_BACK: begin
            ctrl.op   = OP_INS_BACK1;
            state_nxt = S_BACK2;
          end
          K_INS_AFTER, K_DEL_MID: begin
            state_nxt = S_WALK;
          end
          K_DEL_HEAD: begin
            ctrl.op   = OP_RD;
            state_nxt = S_DEL_HEAD;
          end
          K_READ: begin
            ctrl.op   = OP_RD;
            state_nxt = S_RO_EMIT;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_WALK: begin
        ctrl.op = OP_RD;
        if (!stat.cnt_zero) begin
          state_nxt = S_STEP;
        end else if (stat.kind == K_INS_AFTER) begin
          state_nxt = S_AFT1;
        end else begin
          state_nxt = S_DEL_ADV;
        end
      end
      S_STEP: begin
        ctrl.op   = OP_ADV;
        state_nxt = S_WALK;
      end
      S_AFT1: begin
        ctrl.op   = OP_INS_AFT1;
        state_nxt = S_AFT2;
      end
      S_AFT2: begin
        ctrl.op   = OP_INS_AFT2;
        state_nxt = S_EMIT;
      end
      S_BACK2: begin
        ctrl.op   = OP_INS_BACK2;
        state_nxt = S_EMIT;
      end
      S_DEL_HEAD: begin
        ctrl.op   = OP_DEL_HEAD;
        state_nxt = S_EMIT;
      end
      // Step from the predecessor onto the victim, then fetch its link.
      S_DEL_ADV: begin
        ctrl.op   = OP_ADV;
        state_nxt = S_DEL_RD;
      end
      S_DEL_RD: begin
        ctrl.op   = OP_RD;
        state_nxt = S_DEL_MID;
      end
      S_DEL_MID: begin
        ctrl.op   = OP_DEL_MID;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RO_RD: begin
        ctrl.op   = OP_RD;
        state_nxt = S_RO_EMIT;
      end
      S_RO_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          ctrl.op   = OP_ADV;
          state_nxt = stat.cnt_one ? S_IDLE : S_RO_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_LOAD) |-> (state_r == S_IDLE))
    else $error("word loaded outside idle");

  a_dispatch_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DISPATCH))
    else $error("accepted word not dispatched");

  a_emit_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit && state_r == S_EMIT) |=> (state_r == S_IDLE))
    else $error("single result did not end the command");

endmodule

FILE: rtl/core/positional_linked_list_engine.sv
// Insert-after and delete past the head walk the list one link at a time through the link
// memory read port; read-out gives its words one by one, each held until the output is free.
// One command is in work at a time; the next is taken once its last result is registered.
// Reset (synchronous, rst_n low) empties the list and frees the pool at once; node
// memories are not cleared.
module positional_linked_list_engine #(
  parameter int POOL_DEPTH = plle_pkg::DEFAULT_POOL_DEPTH,
  parameter int DATA_WIDTH = plle_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // command[2:0], position[9:3], value[41:10], zero fill
  input  logic [plle_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // item_value[31:0], item_count[38:32], zero fill
  output logic [plle_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [plle_pkg::STATUS_W-1:0]    out_tuser,
  output logic                             out_tlast
);
  import plle_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  plle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  plle_datapath #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
